// ----- hw/rtl/two_wire_jtag_tap_monitor_assert.svh -----
// Assertion macros for the two-wire JTAG TAP monitor checker.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef TWO_WIRE_JTAG_TAP_MONITOR_ASSERT_SVH
`define TWO_WIRE_JTAG_TAP_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TWJT_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tap monitor check failed");

// Next-cycle implication, disabled during reset.
`define TWJT_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tap monitor check failed");

`endif

// ----- hw/rtl/twjt_pkg.sv -----
// Shared types, constants and TAP transition function for the TAP monitor.
// No dependencies.
`default_nettype none

package twjt_pkg;

    localparam int SHIFT_WIDTH = 64;
    localparam int FRAME_W     = 64;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd3500;

    // TAP controller states
    localparam logic [3:0] ST_RESET      = 4'd0;
    localparam logic [3:0] ST_IDLE       = 4'd1;
    localparam logic [3:0] ST_SEL_DR     = 4'd2;
    localparam logic [3:0] ST_CAPTURE_DR = 4'd3;
    localparam logic [3:0] ST_SHIFT_DR   = 4'd4;
    localparam logic [3:0] ST_EXIT1_DR   = 4'd5;
    localparam logic [3:0] ST_PAUSE_DR   = 4'd6;
    localparam logic [3:0] ST_EXIT2_DR   = 4'd7;
    localparam logic [3:0] ST_UPDATE_DR  = 4'd8;
    localparam logic [3:0] ST_SEL_IR     = 4'd9;
    localparam logic [3:0] ST_CAPTURE_IR = 4'd10;
    localparam logic [3:0] ST_SHIFT_IR   = 4'd11;
    localparam logic [3:0] ST_EXIT1_IR   = 4'd12;
    localparam logic [3:0] ST_PAUSE_IR   = 4'd13;
    localparam logic [3:0] ST_EXIT2_IR   = 4'd14;
    localparam logic [3:0] ST_UPDATE_IR  = 4'd15;

    // One falling edge after classification
    typedef struct packed {
        logic [TIME_W-1:0] edge_time;
        logic              line;
        logic              late;
        logic              timeout;
    } edge_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [3:0] tap_next(input logic [3:0] s, input logic tms);
        logic [3:0] n;
        unique case (s)
            ST_RESET:      n = tms ? ST_RESET     : ST_IDLE;
            ST_IDLE:       n = tms ? ST_SEL_DR    : ST_IDLE;
            ST_SEL_DR:     n = tms ? ST_SEL_IR    : ST_CAPTURE_DR;
            ST_CAPTURE_DR: n = tms ? ST_EXIT1_DR  : ST_SHIFT_DR;
            ST_SHIFT_DR:   n = tms ? ST_EXIT1_DR  : ST_SHIFT_DR;
            ST_EXIT1_DR:   n = tms ? ST_UPDATE_DR : ST_PAUSE_DR;
            ST_PAUSE_DR:   n = tms ? ST_EXIT2_DR  : ST_PAUSE_DR;
            ST_EXIT2_DR:   n = tms ? ST_UPDATE_DR : ST_SHIFT_DR;
            ST_UPDATE_DR:  n = tms ? ST_SEL_DR    : ST_IDLE;
            ST_SEL_IR:     n = tms ? ST_RESET     : ST_CAPTURE_IR;
            ST_CAPTURE_IR: n = tms ? ST_EXIT1_IR  : ST_SHIFT_IR;
            ST_SHIFT_IR:   n = tms ? ST_EXIT1_IR  : ST_SHIFT_IR;
            ST_EXIT1_IR:   n = tms ? ST_UPDATE_IR : ST_PAUSE_IR;
            ST_PAUSE_IR:   n = tms ? ST_EXIT2_IR  : ST_PAUSE_IR;
            ST_EXIT2_IR:   n = tms ? ST_UPDATE_IR : ST_SHIFT_IR;
            ST_UPDATE_IR:  n = tms ? ST_SEL_DR    : ST_IDLE;
            default:       n = ST_RESET;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/twjt_fifo.sv -----
// Short word queue between the front and back of the TAP monitor.
// Depends on twjt_pkg.
`default_nettype none

module twjt_fifo (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  twjt_pkg::edge_word_t push_word,
    input  wire                  pop,
    output twjt_pkg::edge_word_t head_word,
    output twjt_pkg::q_status_t  status
);

    localparam int PTR_W = $clog2(twjt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(twjt_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(twjt_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(twjt_pkg::QUEUE_DEPTH - 1);

    twjt_pkg::edge_word_t mem_reg [twjt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == DEPTH_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_word    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/twjt_front.sv -----
// Front of the TAP monitor: input handshake, timeout register, high-time check.
// Depends on twjt_pkg.
`default_nettype none

module twjt_front (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire [twjt_pkg::TIME_W-1:0]    cfg_wdata,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire [twjt_pkg::TIME_W-1:0]    edge_time,
    input  wire [twjt_pkg::TIME_W-1:0]    rise_time,
    input  wire                           line_at_edge,
    input  wire                           line_delayed,
    input  twjt_pkg::q_status_t           q_status,
    output logic                          push,
    output twjt_pkg::edge_word_t          push_word
);

    logic [twjt_pkg::TIME_W-1:0] timeout_reg;
    logic [twjt_pkg::TIME_W-1:0] high_time;

    // high time wraps modulo 2^32
    assign high_time = rise_time - edge_time;

    assign in_stall             = q_status.full;
    assign push                 = in_valid && !q_status.full;
    assign push_word.edge_time  = edge_time;
    assign push_word.line       = line_at_edge;
    assign push_word.late       = line_delayed;
    assign push_word.timeout    = (high_time > timeout_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= twjt_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/twjt_back.sv -----
// Back of the TAP monitor: slot sequencer, TAP controller, shift capture, frame register.
// Depends on twjt_pkg.
`default_nettype none

module twjt_back (
    input  wire                              clk,
    input  wire                              rst_n,
    input  twjt_pkg::edge_word_t             head_word,
    input  twjt_pkg::q_status_t              q_status,
    output logic                             pop,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [twjt_pkg::TIME_W-1:0]      start_time,
    output logic [twjt_pkg::TIME_W-1:0]      end_time,
    output logic [twjt_pkg::FRAME_W-1:0]     shifted_in,
    output logic [twjt_pkg::FRAME_W-1:0]     shifted_out,
    output logic [twjt_pkg::COUNT_W-1:0]     bit_count,
    output logic [3:0]                       old_state
);

    localparam logic [1:0] SLOT_IDLE = 2'd0;
    localparam logic [1:0] SLOT_TMS  = 2'd1;
    localparam logic [1:0] SLOT_TDI  = 2'd2;
    localparam logic [1:0] SLOT_TDO  = 2'd3;

    localparam int SW = twjt_pkg::SHIFT_WIDTH;

    logic [1:0]                    slot_reg, slot_next;
    logic [3:0]                    tap_reg, tap_next;
    logic                          tms_reg, tms_next;
    logic [SW-1:0]                 in_sh_reg, in_sh_next;
    logic [SW-1:0]                 out_sh_reg, out_sh_next;
    logic [SW-1:0]                 out_sh_upd;
    logic [twjt_pkg::COUNT_W-1:0]  cnt_reg, cnt_next, cnt_upd;
    logic [twjt_pkg::TIME_W-1:0]   start_reg, start_next;
    logic [3:0]                    tap_step;
    logic                          shifting, emit, go;
    logic                          out_valid_reg;

    assign shifting = (tap_reg == twjt_pkg::ST_SHIFT_DR) || (tap_reg == twjt_pkg::ST_SHIFT_IR);
    assign tap_step = twjt_pkg::tap_next(tap_reg, tms_reg);
    assign emit     = (slot_reg == SLOT_TDO) && (tap_step != tap_reg);
    // a word that leaves a frame waits for the frame register to free up
    assign go       = !q_status.empty && (!emit || !out_valid_reg || !out_stall);
    assign pop      = go;

    assign out_sh_upd = shifting ? {out_sh_reg[SW-2:0], head_word.late} : out_sh_reg;
    assign cnt_upd    = (shifting && cnt_reg != twjt_pkg::COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        slot_next   = slot_reg;
        tap_next    = tap_reg;
        tms_next    = tms_reg;
        in_sh_next  = in_sh_reg;
        out_sh_next = out_sh_reg;
        cnt_next    = cnt_reg;
        start_next  = start_reg;
        unique case (slot_reg)
            SLOT_IDLE:
            begin
                slot_next = SLOT_TMS;
            end
            SLOT_TMS:
            begin
                slot_next = SLOT_TDI;
                tms_next  = head_word.line;
            end
            SLOT_TDI:
            begin
                slot_next = SLOT_TDO;
                if (shifting)
                begin
                    in_sh_next = {in_sh_reg[SW-2:0], head_word.line};
                end
            end
            SLOT_TDO:
            begin
                slot_next = SLOT_TMS;
                if (emit)
                begin
                    tap_next    = tap_step;
                    start_next  = head_word.edge_time;
                    in_sh_next  = '0;
                    out_sh_next = '0;
                    cnt_next    = '0;
                end
                else
                begin
                    out_sh_next = out_sh_upd;
                    cnt_next    = cnt_upd;
                end
            end
            default:
            begin
                slot_next = SLOT_TMS;
            end
        endcase
        // long clock high time drops the link back to reset
        if (head_word.timeout)
        begin
            slot_next = SLOT_IDLE;
            tap_next  = twjt_pkg::ST_RESET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= SLOT_TMS;
            tap_reg    <= twjt_pkg::ST_RESET;
            tms_reg    <= 1'b0;
            in_sh_reg  <= '0;
            out_sh_reg <= '0;
            cnt_reg    <= '0;
            start_reg  <= '0;
        end
        else if (go)
        begin
            slot_reg   <= slot_next;
            tap_reg    <= tap_next;
            tms_reg    <= tms_next;
            in_sh_reg  <= in_sh_next;
            out_sh_reg <= out_sh_next;
            cnt_reg    <= cnt_next;
            start_reg  <= start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            start_time  <= start_reg;
            end_time    <= head_word.edge_time;
            shifted_in  <= twjt_pkg::FRAME_W'(in_sh_reg);
            shifted_out <= twjt_pkg::FRAME_W'(out_sh_upd);
            bit_count   <= cnt_upd;
            old_state   <= tap_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/two_wire_jtag_tap_monitor.sv -----
// Top level of the two-wire JTAG TAP monitor: front, word queue and back.
// Depends on twjt_pkg, twjt_front, twjt_fifo and twjt_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | to block  | in_valid / in_stall  | edge_time rise_time line_at_edge line_delayed
//   out     | from block| out_valid / out_stall| start_time end_time shifted_in shifted_out
//           |           |                      | bit_count old_state
//   cfg     | to block  | cfg_we               | cfg_wdata (timeout_ticks)
//
// One word per cycle while in_stall is low; an accepted word passes through the queue to
// the back, and a frame it leaves shows on out from the edge at which the back takes it.
// The back handles one word per cycle in its slot and TAP registers, unless a frame waits.
// in_stall rises only when the four-word queue is full, which happens while a frame
// waits on out_stall and the next state change is due.
// Reset is asynchronous, active low, and needs no clearing pass.
`default_nettype none

module two_wire_jtag_tap_monitor (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [twjt_pkg::TIME_W-1:0]       cfg_wdata,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [twjt_pkg::TIME_W-1:0]       edge_time,
    input  wire [twjt_pkg::TIME_W-1:0]       rise_time,
    input  wire                              line_at_edge,
    input  wire                              line_delayed,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [twjt_pkg::TIME_W-1:0]      start_time,
    output logic [twjt_pkg::TIME_W-1:0]      end_time,
    output logic [twjt_pkg::FRAME_W-1:0]     shifted_in,
    output logic [twjt_pkg::FRAME_W-1:0]     shifted_out,
    output logic [twjt_pkg::COUNT_W-1:0]     bit_count,
    output logic [3:0]                       old_state
);

    twjt_pkg::edge_word_t push_word;
    twjt_pkg::edge_word_t head_word;
    twjt_pkg::q_status_t  q_status;
    logic                 push;
    logic                 pop;

    twjt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .edge_time    (edge_time),
        .rise_time    (rise_time),
        .line_at_edge (line_at_edge),
        .line_delayed (line_delayed),
        .q_status     (q_status),
        .push         (push),
        .push_word    (push_word)
    );

    twjt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .status    (q_status)
    );

    twjt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_word   (head_word),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .start_time  (start_time),
        .end_time    (end_time),
        .shifted_in  (shifted_in),
        .shifted_out (shifted_out),
        .bit_count   (bit_count),
        .old_state   (old_state)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/twjt_checker.sv -----
// Port-level checks for the TAP monitor, bound to the top level.
// Depends on twjt_pkg and two_wire_jtag_tap_monitor_assert.svh.
`default_nettype none

`include "two_wire_jtag_tap_monitor_assert.svh"

module twjt_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              out_valid,
    input wire                              out_stall,
    input wire [twjt_pkg::TIME_W-1:0]       start_time,
    input wire [twjt_pkg::TIME_W-1:0]       end_time,
    input wire [twjt_pkg::FRAME_W-1:0]      shifted_out,
    input wire [twjt_pkg::COUNT_W-1:0]      bit_count
);

    // hold a stalled frame
    `TWJT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `TWJT_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(start_time) && $stable(end_time) && $stable(shifted_out))
    // TDO bits only enter together with a count step
    `TWJT_ASSERT_IMP(a_tdo_needs_count, out_valid && (bit_count == '0), shifted_out == '0)
    // no frame straight out of reset
    `TWJT_ASSERT_IMP(a_no_frame_at_reset, $rose(rst_n), !out_valid)

endmodule

bind two_wire_jtag_tap_monitor twjt_checker u_twjt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .start_time  (start_time),
    .end_time    (end_time),
    .shifted_out (shifted_out),
    .bit_count   (bit_count)
);

`default_nettype wire

// ----- sim/two_wire_jtag_tap_monitor_tb.sv -----
// Self-checking testbench for the two-wire JTAG TAP monitor: drives clock edge words,
// predicts the TAP state frames in a behavioral model and compares every field.
// Depends on twjt_pkg and two_wire_jtag_tap_monitor.
`timescale 1ns / 100ps

module two_wire_jtag_tap_monitor_tb;

    typedef enum logic [1:0] {SLOT_IDLE, SLOT_TMS, SLOT_TDI, SLOT_TDO} slot_t;

    typedef struct {
        logic [twjt_pkg::TIME_W-1:0]  start_time;
        logic [twjt_pkg::TIME_W-1:0]  end_time;
        logic [twjt_pkg::FRAME_W-1:0] shifted_in;
        logic [twjt_pkg::FRAME_W-1:0] shifted_out;
        logic [twjt_pkg::COUNT_W-1:0] bit_count;
        logic [3:0]                   old_state;
    } tap_frame_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_we       = 1'b0;
    logic [twjt_pkg::TIME_W-1:0]   cfg_wdata    = '0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [twjt_pkg::TIME_W-1:0]   edge_time    = '0;
    logic [twjt_pkg::TIME_W-1:0]   rise_time    = '0;
    logic                          line_at_edge = 1'b0;
    logic                          line_delayed = 1'b0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic [twjt_pkg::TIME_W-1:0]   start_time;
    logic [twjt_pkg::TIME_W-1:0]   end_time;
    logic [twjt_pkg::FRAME_W-1:0]  shifted_in;
    logic [twjt_pkg::FRAME_W-1:0]  shifted_out;
    logic [twjt_pkg::COUNT_W-1:0]  bit_count;
    logic [3:0]                    old_state;

    // TAP transition tables, indexed by the current state
    logic [3:0] tap_on_zero [16] = '{twjt_pkg::ST_IDLE, twjt_pkg::ST_IDLE,
        twjt_pkg::ST_CAPTURE_DR, twjt_pkg::ST_SHIFT_DR, twjt_pkg::ST_SHIFT_DR,
        twjt_pkg::ST_PAUSE_DR, twjt_pkg::ST_PAUSE_DR, twjt_pkg::ST_SHIFT_DR,
        twjt_pkg::ST_IDLE, twjt_pkg::ST_CAPTURE_IR, twjt_pkg::ST_SHIFT_IR,
        twjt_pkg::ST_SHIFT_IR, twjt_pkg::ST_PAUSE_IR, twjt_pkg::ST_PAUSE_IR,
        twjt_pkg::ST_SHIFT_IR, twjt_pkg::ST_IDLE};
    logic [3:0] tap_on_one [16] = '{twjt_pkg::ST_RESET, twjt_pkg::ST_SEL_DR,
        twjt_pkg::ST_SEL_IR, twjt_pkg::ST_EXIT1_DR, twjt_pkg::ST_EXIT1_DR,
        twjt_pkg::ST_UPDATE_DR, twjt_pkg::ST_EXIT2_DR, twjt_pkg::ST_UPDATE_DR,
        twjt_pkg::ST_SEL_DR, twjt_pkg::ST_RESET, twjt_pkg::ST_EXIT1_IR,
        twjt_pkg::ST_EXIT1_IR, twjt_pkg::ST_UPDATE_IR, twjt_pkg::ST_EXIT2_IR,
        twjt_pkg::ST_UPDATE_IR, twjt_pkg::ST_SEL_DR};

    // Monitor state as predicted
    logic [twjt_pkg::TIME_W-1:0]      timeout_reg = twjt_pkg::TIMEOUT_RESET;
    slot_t                            pred_slot   = SLOT_TMS;
    logic [3:0]                       pred_tap    = twjt_pkg::ST_RESET;
    logic                             pred_tms    = 1'b0;
    logic [twjt_pkg::SHIFT_WIDTH-1:0] pred_in     = '0;
    logic [twjt_pkg::SHIFT_WIDTH-1:0] pred_out    = '0;
    logic [twjt_pkg::COUNT_W-1:0]     pred_count  = '0;
    logic [twjt_pkg::TIME_W-1:0]      pred_start  = '0;

    tap_frame_t  pending_frames[$];
    int unsigned mismatches    = 0;
    int unsigned items_sent    = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    int unsigned rx_hold       = 0;
    int unsigned scan_exit_pct = 10;
    logic [twjt_pkg::TIME_W-1:0] now_t = '0;

    two_wire_jtag_tap_monitor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .edge_time    (edge_time),
        .rise_time    (rise_time),
        .line_at_edge (line_at_edge),
        .line_delayed (line_delayed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .start_time   (start_time),
        .end_time     (end_time),
        .shifted_in   (shifted_in),
        .shifted_out  (shifted_out),
        .bit_count    (bit_count),
        .old_state    (old_state)
    );

    always #4 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    task automatic predict_edge(input logic [twjt_pkg::TIME_W-1:0] et,
                                input logic [twjt_pkg::TIME_W-1:0] rt,
                                input logic la, input logic ld);
        tap_frame_t                  f;
        logic [3:0]                  nxt;
        logic [twjt_pkg::TIME_W-1:0] high_ticks;
        logic                        shifting;
        shifting = (pred_tap == twjt_pkg::ST_SHIFT_DR) || (pred_tap == twjt_pkg::ST_SHIFT_IR);
        case (pred_slot)
            SLOT_IDLE: pred_slot = SLOT_TMS;
            SLOT_TMS:
            begin
                pred_slot = SLOT_TDI;
                pred_tms  = la;
            end
            SLOT_TDI:
            begin
                pred_slot = SLOT_TDO;
                if (shifting)
                    pred_in = {pred_in[twjt_pkg::SHIFT_WIDTH-2:0], la};
            end
            default:
            begin
                pred_slot = SLOT_TMS;
                if (shifting)
                begin
                    pred_out = {pred_out[twjt_pkg::SHIFT_WIDTH-2:0], ld};
                    if (pred_count != twjt_pkg::COUNT_MAX)
                        pred_count = pred_count + 1'b1;
                end
                nxt = pred_tms ? tap_on_one[pred_tap] : tap_on_zero[pred_tap];
                if (nxt != pred_tap)
                begin
                    f.start_time  = pred_start;
                    f.end_time    = et;
                    f.shifted_in  = twjt_pkg::FRAME_W'(pred_in);
                    f.shifted_out = twjt_pkg::FRAME_W'(pred_out);
                    f.bit_count   = pred_count;
                    f.old_state   = pred_tap;
                    pending_frames.push_back(f);
                    pred_start = et;
                    pred_tap   = nxt;
                    pred_in    = '0;
                    pred_out   = '0;
                    pred_count = '0;
                end
            end
        endcase
        // the timeout lands after the edge, so a frame from it still stands
        high_ticks = rt - et;
        if (high_ticks > timeout_reg)
        begin
            pred_slot = SLOT_IDLE;
            pred_tap  = twjt_pkg::ST_RESET;
        end
    endtask

    task automatic send_edge(input logic [twjt_pkg::TIME_W-1:0] et,
                             input logic [twjt_pkg::TIME_W-1:0] rt,
                             input logic la, input logic ld);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        edge_time    <= et;
        rise_time    <= rt;
        line_at_edge <= la;
        line_delayed <= ld;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        predict_edge(et, rt, la, ld);
    endtask

    function automatic logic [twjt_pkg::TIME_W-1:0] normal_high();
        return $urandom_range(timeout_reg < 60 ? timeout_reg : 60, 0);
    endfunction

    function automatic logic [twjt_pkg::TIME_W-1:0] long_high();
        if (timeout_reg == '1)
            return timeout_reg;
        return $urandom_range(32'hFFFF_FFFF, timeout_reg + 1);
    endfunction

    task automatic send_item(input logic [twjt_pkg::TIME_W-1:0] high_ticks, input logic la,
                             input logic ld);
        now_t = now_t + $urandom_range(3000, 1);
        send_edge(now_t, now_t + high_ticks, la, ld);
    endtask

    // Send words until a TDO slot has passed; realigns after a dropped slot.
    task automatic send_tap_bit(input logic tms, input logic tdi, input logic tdo);
        slot_t was;
        do
        begin
            was = pred_slot;
            case (was)
                SLOT_TMS: send_item(normal_high(), tms, rand_bit());
                SLOT_TDI: send_item(normal_high(), tdi, rand_bit());
                SLOT_TDO: send_item(normal_high(), rand_bit(), tdo);
                default:  send_item(normal_high(), rand_bit(), rand_bit());
            endcase
        end
        while (was != SLOT_TDO);
    endtask

    // Random walk biased toward long scans
    task automatic walk_bit();
        int unsigned pct;
        case (pred_tap) inside
            twjt_pkg::ST_SHIFT_DR, twjt_pkg::ST_SHIFT_IR: pct = scan_exit_pct;
            twjt_pkg::ST_CAPTURE_DR, twjt_pkg::ST_CAPTURE_IR:
            begin
                scan_exit_pct = ($urandom_range(3) == 0) ? 1 : 10;
                pct = 50;
            end
            twjt_pkg::ST_PAUSE_DR, twjt_pkg::ST_PAUSE_IR: pct = 30;
            twjt_pkg::ST_RESET: pct = 20;
            twjt_pkg::ST_IDLE:  pct = 40;
            default:            pct = 50;
        endcase
        send_tap_bit($urandom_range(99) < pct, rand_bit(), rand_bit());
    endtask

    task automatic drain_frames();
        @(negedge clk) in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [twjt_pkg::TIME_W-1:0] value);
        drain_frames();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        timeout_reg = value;
    endtask

    task automatic test_directed();
        send_edge(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
        send_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // high time one past the limit, across the wrap of the time counter
        send_edge(32'hFFFF_FFFF, 32'h0000_0DAC, 1'b0, 1'b1);
        // high time right at the limit
        send_edge(32'h8000_0000, 32'h8000_0DAC, 1'b0, 1'b1);
        send_tap_bit(1'b0, 1'b1, 1'b1);
        send_tap_bit(1'b1, 1'b0, 1'b1);
        send_tap_bit(1'b0, 1'b1, 1'b0);
        send_tap_bit(1'b0, 1'b1, 1'b1);
        send_tap_bit(1'b0, 1'b1, 1'b1);
        send_tap_bit(1'b0, 1'b0, 1'b0);
        send_tap_bit(1'b1, 1'b1, 1'b0);
        // rise before edge: the modular high time is huge
        send_edge(32'h0000_0040, 32'h0000_003F, 1'b1, 1'b0);
    endtask

    task automatic test_timeout_register();
        write_timeout(32'd1);
        send_item(32'd1, 1'b0, 1'b1);
        send_item(32'd2, 1'b1, 1'b1);
        repeat (8) walk_bit();
        write_timeout(32'd0);
        repeat (3) send_item(32'd0, rand_bit(), rand_bit());
        send_item(32'd1, 1'b0, 1'b0);
        repeat (8) walk_bit();
        write_timeout(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        repeat (8) walk_bit();
        write_timeout($urandom_range(5000, 1));
        repeat (8) walk_bit();
        write_timeout(twjt_pkg::TIMEOUT_RESET);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned first;
        int unsigned r;
        first = items_sent;
        while (items_sent - first < count)
        begin
            r = $urandom_range(99);
            if (r < 96)
                walk_bit();
            else if (r < 98)
                send_edge($urandom, $urandom, rand_bit(), rand_bit());
            else
                send_item(long_high(), rand_bit(), rand_bit());
        end
    endtask

    task automatic test_shift_history();
        repeat (5) send_tap_bit(1'b1, 1'b0, 1'b0);
        send_tap_bit(1'b0, 1'b0, 1'b0);
        send_tap_bit(1'b1, 1'b0, 1'b0);
        send_tap_bit(1'b1, 1'b0, 1'b0);
        send_tap_bit(1'b0, 1'b0, 1'b0);
        send_tap_bit(1'b0, 1'b0, 1'b0);
        repeat (70) send_tap_bit(1'b0, rand_bit(), rand_bit());
        send_tap_bit(1'b1, rand_bit(), rand_bit());
        send_tap_bit(1'b1, 1'b0, 1'b0);
        send_tap_bit(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_backpressure();
        int unsigned saved_tx;
        saved_tx    = tx_idle_pct;
        tx_idle_pct = 0;
        rx_hold     = 300;
        repeat (5) send_tap_bit(1'b1, 1'b0, 1'b0);
        // reset, idle, select-DR, select-IR and back: a frame on every bit
        repeat (12)
        begin
            send_tap_bit(1'b0, rand_bit(), rand_bit());
            repeat (3) send_tap_bit(1'b1, rand_bit(), rand_bit());
        end
        drain_frames();
        tx_idle_pct = saved_tx;
    endtask

    // Receiver: hold off until rx_hold counts down to zero when asked, otherwise stall at random
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_stall <= 1'b1;
            rx_hold = rx_hold - 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : frame_check
        tap_frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: frame with none expected, state %0d end %h",
                             $time, old_state, end_time);
            end
            else
            begin
                want = pending_frames.pop_front();
                check_field("start_time", 64'(want.start_time), 64'(start_time));
                check_field("end_time", 64'(want.end_time), 64'(end_time));
                check_field("shifted_in", 64'(want.shifted_in), 64'(shifted_in));
                check_field("shifted_out", 64'(want.shifted_out), 64'(shifted_out));
                check_field("bit_count", 64'(want.bit_count), 64'(bit_count));
                check_field("old_state", 64'(want.old_state), 64'(old_state));
            end
        end
    end

    initial
    begin
        now_t = $urandom;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        tx_idle_pct = 25;
        rx_idle_pct = 59;
        test_directed();
        test_timeout_register();
        test_random_traffic(160);

        tx_idle_pct = 59;
        rx_idle_pct = 25;
        test_shift_history();
        write_timeout($urandom_range(100000, 20));
        test_random_traffic(160);
        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_timeout(twjt_pkg::TIMEOUT_RESET);
        test_random_traffic(140);

        drain_frames();
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- two_wire_jtag_tap_monitor.f -----
+incdir+hw/rtl
hw/rtl/twjt_pkg.sv
hw/rtl/twjt_fifo.sv
hw/rtl/twjt_front.sv
hw/rtl/twjt_back.sv
hw/rtl/two_wire_jtag_tap_monitor.sv
hw/rtl/twjt_checker.sv
sim/two_wire_jtag_tap_monitor_tb.sv
